@@ rtl/pet_pkg.sv @@
// ----------------------------------------------------------------------------
// pet_pkg: shared types and constants for the pointer event tracker
// Event codes, button codes, register indexes and the saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pet_pkg;

	// Width of the position and wheel accumulators.
	localparam int unsigned POS_WIDTH    = 24;
	// Number of tracked buttons (left, right, middle).
	localparam int unsigned BUTTON_COUNT = 3;
	// Width of a velocity, one bit wider than a position.
	localparam int unsigned VEL_WIDTH    = POS_WIDTH + 1;
	// Width of a motion step and of a screen bound.
	localparam int unsigned STEP_WIDTH   = 16;
	localparam int unsigned BOUND_WIDTH  = 16;

	// Byte-padded stream word widths.
	localparam int unsigned IN_DATA_WIDTH  = 88;
	localparam int unsigned OUT_DATA_WIDTH = 160;

	typedef logic signed [POS_WIDTH-1:0] pos_t;
	typedef logic signed [VEL_WIDTH-1:0] vel_t;
	typedef logic [BUTTON_COUNT-1:0]     btn_t;

	typedef enum logic [2:0] {
		CMD_MOTION   = 3'd0,
		CMD_BTN_DOWN = 3'd1,
		CMD_BTN_UP   = 3'd2,
		CMD_TICK     = 3'd3,
		CMD_WARP     = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		BTN_LEFT       = 3'd0,
		BTN_MIDDLE     = 3'd1,
		BTN_RIGHT      = 3'd2,
		BTN_WHEEL_UP   = 3'd3,
		BTN_WHEEL_DOWN = 3'd4
	} btn_code_t;

	// Bit positions of the held flags.
	localparam int unsigned HELD_LEFT   = 0;
	localparam int unsigned HELD_RIGHT  = 1;
	localparam int unsigned HELD_MIDDLE = 2;

	// Configuration register indexes.
	localparam logic [1:0] REG_POINTER_CAPTURED = 2'd0;
	localparam logic [1:0] REG_SCREEN_WIDTH     = 2'd1;
	localparam logic [1:0] REG_SCREEN_HEIGHT    = 2'd2;

	// One input event, unpacked from the stream word.
	typedef struct packed {
		logic [2:0]                   command;
		logic signed [STEP_WIDTH-1:0] step_x;
		logic signed [STEP_WIDTH-1:0] step_y;
		logic [2:0]                   button_code;
		pos_t                         warp_x;
		pos_t                         warp_y;
	} item_t;

	// Saturate a sum that is one bit wider than a position.
	function automatic pos_t sat_pos(input logic signed [POS_WIDTH:0] v);
		pos_t r;
		if (v[POS_WIDTH] != v[POS_WIDTH-1]) begin
			r = {v[POS_WIDTH], {(POS_WIDTH-1){~v[POS_WIDTH]}}};
		end else begin
			r = v[POS_WIDTH-1:0];
		end
		return r;
	endfunction

	// Clamp a position to the range zero through top.
	function automatic pos_t clamp_pos(input pos_t v, input logic [BOUND_WIDTH-1:0] top);
		pos_t top_s;
		pos_t r;
		top_s = pos_t'({{(POS_WIDTH-BOUND_WIDTH){1'b0}}, top});
		if (v[POS_WIDTH-1]) begin
			r = '0;
		end else if (v > top_s) begin
			r = top_s;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/pointer_event_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// pointer_event_tracker_unit: pointer position, wheel and button tracker
// Takes one pointer event per word and emits a status word on each frame tick.
// ----------------------------------------------------------------------------
// The unit takes one event word per clock and keeps the pointer position, the
// wheel count and the held buttons. Each accepted word is latched in an input
// register and applied to the state when it leaves that register; a frame
// tick leaves it only when the output register is free or being emptied,
// and its status word goes out via the output register. The sustained
// rate is one event per cycle; the only thing that stops the slave side is a
// frame tick sitting in the input register while the output register holds a
// status word that is not taken in that cycle. Motion and wheel steps saturate
// at the signed 24-bit range, and while the pointer is not captured the
// position is then clamped to zero through the screen width and height. A warp
// loads x and y together with their tick baselines, so the next tick reports
// no x/y motion from the warp itself. Configuration writes take effect at once
// and are meant for idle periods.
`default_nettype none

module pointer_event_tracker_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Configuration write port.
	input  wire logic                                 cfg_wr_en,
	input  wire logic [1:0]                           cfg_index,
	input  wire logic [pet_pkg::BOUND_WIDTH-1:0]      cfg_wdata,
	// Event stream.
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// s_tdata, low bit up: step_x[15:0], step_y[31:16], button_code[34:32],
	// warp_x[58:35], warp_y[82:59], zero fill [87:83].
	input  wire logic [pet_pkg::IN_DATA_WIDTH-1:0]    s_tdata,
	// s_tuser: command[2:0].
	input  wire logic [2:0]                           s_tuser,
	// Status stream.
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// m_tdata, low bit up: position_x[23:0], position_y[47:24],
	// wheel_position[71:48], velocity_x[96:72], velocity_y[121:97],
	// velocity_wheel[146:122], buttons_held[149:147], press_edges[152:150],
	// release_edges[155:153], axes_moved[156], wheel_moved[157], zero fill.
	output logic [pet_pkg::OUT_DATA_WIDTH-1:0]        m_tdata
);
	import pet_pkg::*;

	localparam int unsigned RES_WIDTH = 3 * POS_WIDTH + 3 * VEL_WIDTH + 3 * BUTTON_COUNT + 2;

	// Configuration registers.
	logic                   captured_q;
	logic [BOUND_WIDTH-1:0] screen_width_q;
	logic [BOUND_WIDTH-1:0] screen_height_q;

	// Tracker state.
	pos_t pos_x_q, pos_y_q, wheel_q;
	pos_t base_x_q, base_y_q, base_wheel_q;
	btn_t held_now_q, held_before_q;

	// Input register.
	logic  valid_s1;
	item_t item_s1;

	// Output register.
	logic                      valid_s2;
	logic [OUT_DATA_WIDTH-1:0] data_s2;

	// Stage control.
	logic  out_free;
	logic  is_tick_s1;
	logic  advance;
	logic  load_out;
	item_t item_in;

	// Next state.
	pos_t pos_x_d, pos_y_d, wheel_d;
	pos_t base_x_d, base_y_d, base_wheel_d;
	btn_t held_now_d, held_before_d;
	pos_t sat_x, sat_y;
	btn_t btn_bit;
	logic btn_is_wheel_up, btn_is_wheel_down;

	// Tick status.
	vel_t                      vel_x, vel_y, vel_w;
	btn_t                      press, rel_edges;
	logic                      axes_moved, wheel_moved;
	logic [RES_WIDTH-1:0]      res_bits;

	// ------------------------------------------------------------------
	// Handshake: a tick may only leave stage 1 when the output register
	// is free or being emptied; every other event leaves unconditionally.
	// ------------------------------------------------------------------
	assign out_free   = !valid_s2 || m_tready;
	assign is_tick_s1 = (item_s1.command == CMD_TICK);
	assign advance    = valid_s1 && (!is_tick_s1 || out_free);
	assign load_out   = advance && is_tick_s1;
	assign s_tready   = !valid_s1 || advance;

	assign item_in.command     = s_tuser;
	assign item_in.step_x      = s_tdata[15:0];
	assign item_in.step_y      = s_tdata[31:16];
	assign item_in.button_code = s_tdata[34:32];
	assign item_in.warp_x      = s_tdata[58:35];
	assign item_in.warp_y      = s_tdata[82:59];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
		end
	end

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			captured_q      <= 1'b0;
			screen_width_q  <= 16'd1024;
			screen_height_q <= 16'd768;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_POINTER_CAPTURED: captured_q <= cfg_wdata[0];
				REG_SCREEN_WIDTH:     screen_width_q <= cfg_wdata;
				REG_SCREEN_HEIGHT:    screen_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Event decode and state update.
	// ------------------------------------------------------------------
	always_comb begin
		btn_bit           = '0;
		btn_is_wheel_up   = 1'b0;
		btn_is_wheel_down = 1'b0;
		case (item_s1.button_code)
			BTN_LEFT:       btn_bit[HELD_LEFT] = 1'b1;
			BTN_MIDDLE:     btn_bit[HELD_MIDDLE] = 1'b1;
			BTN_RIGHT:      btn_bit[HELD_RIGHT] = 1'b1;
			BTN_WHEEL_UP:   btn_is_wheel_up = 1'b1;
			BTN_WHEEL_DOWN: btn_is_wheel_down = 1'b1;
			default: ;
		endcase
	end

	assign sat_x = sat_pos({pos_x_q[POS_WIDTH-1], pos_x_q} +
		(POS_WIDTH+1)'($signed(item_s1.step_x)));
	assign sat_y = sat_pos({pos_y_q[POS_WIDTH-1], pos_y_q} +
		(POS_WIDTH+1)'($signed(item_s1.step_y)));

	// Velocities and edges are formed from the current state for a tick.
	assign vel_x       = {pos_x_q[POS_WIDTH-1], pos_x_q} - {base_x_q[POS_WIDTH-1], base_x_q};
	assign vel_y       = {pos_y_q[POS_WIDTH-1], pos_y_q} - {base_y_q[POS_WIDTH-1], base_y_q};
	assign vel_w       = {wheel_q[POS_WIDTH-1], wheel_q} -
		{base_wheel_q[POS_WIDTH-1], base_wheel_q};
	assign press       = held_now_q & ~held_before_q;
	assign rel_edges   = ~held_now_q & held_before_q;
	assign axes_moved  = (vel_x != '0) || (vel_y != '0);
	assign wheel_moved = (vel_w != '0);
	assign res_bits    = {wheel_moved, axes_moved, rel_edges, press, held_now_q,
		vel_w, vel_y, vel_x, wheel_q, pos_y_q, pos_x_q};

	always_comb begin
		pos_x_d       = pos_x_q;
		pos_y_d       = pos_y_q;
		wheel_d       = wheel_q;
		base_x_d      = base_x_q;
		base_y_d      = base_y_q;
		base_wheel_d  = base_wheel_q;
		held_now_d    = held_now_q;
		held_before_d = held_before_q;
		case (item_s1.command)
			CMD_MOTION: begin
				if (captured_q) begin
					pos_x_d = sat_x;
					pos_y_d = sat_y;
				end else begin
					pos_x_d = clamp_pos(sat_x, screen_width_q);
					pos_y_d = clamp_pos(sat_y, screen_height_q);
				end
			end
			CMD_BTN_DOWN: begin
				held_now_d = held_now_q | btn_bit;
				if (btn_is_wheel_up) begin
					wheel_d = sat_pos({wheel_q[POS_WIDTH-1], wheel_q} + (POS_WIDTH+1)'(1));
				end else if (btn_is_wheel_down) begin
					wheel_d = sat_pos({wheel_q[POS_WIDTH-1], wheel_q} - (POS_WIDTH+1)'(1));
				end
			end
			CMD_BTN_UP: begin
				held_now_d = held_now_q & ~btn_bit;
			end
			CMD_TICK: begin
				held_before_d = held_now_q;
				base_x_d      = pos_x_q;
				base_y_d      = pos_y_q;
				base_wheel_d  = wheel_q;
			end
			CMD_WARP: begin
				pos_x_d  = item_s1.warp_x;
				pos_y_d  = item_s1.warp_y;
				base_x_d = item_s1.warp_x;
				base_y_d = item_s1.warp_y;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			wheel_q       <= '0;
			base_x_q      <= '0;
			base_y_q      <= '0;
			base_wheel_q  <= '0;
			held_now_q    <= '0;
			held_before_q <= '0;
		end else if (advance) begin
			pos_x_q       <= pos_x_d;
			pos_y_q       <= pos_y_d;
			wheel_q       <= wheel_d;
			base_x_q      <= base_x_d;
			base_y_q      <= base_y_d;
			base_wheel_q  <= base_wheel_d;
			held_now_q    <= held_now_d;
			held_before_q <= held_before_d;
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			data_s2 <= {{(OUT_DATA_WIDTH-RES_WIDTH){1'b0}}, res_bits};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

`ifndef SYNTHESIS
	// A waiting tick must hold the slave side while the status word is stuck.
	property p_tick_stall;
		@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_tick_s1 && valid_s2 && !m_tready) |-> !s_tready;
	endproperty
	a_tick_stall: assert property (p_tick_stall) else $error("tick passed a full output");

	// After a tick the baselines of the buttons and the wheel follow the current state.
	property p_tick_baseline;
		@(posedge clk) disable iff (!arst_n)
		load_out |=> (held_before_q == held_now_q) && (base_wheel_q == wheel_q);
	endproperty
	a_tick_baseline: assert property (p_tick_baseline) else $error("baseline not updated");

	// A warp leaves no x/y motion for the next tick.
	property p_warp_base;
		@(posedge clk) disable iff (!arst_n)
		(advance && (item_s1.command == CMD_WARP)) |=>
			(pos_x_q == base_x_q) && (pos_y_q == base_y_q);
	endproperty
	a_warp_base: assert property (p_warp_base) else $error("warp baseline mismatch");

	// An uncaptured motion keeps x inside the screen bounds.
	property p_motion_clamp;
		@(posedge clk) disable iff (!arst_n)
		(advance && (item_s1.command == CMD_MOTION) && !captured_q) |=>
			!pos_x_q[POS_WIDTH-1] &&
			(pos_x_q <= pos_t'({{(POS_WIDTH-BOUND_WIDTH){1'b0}}, $past(screen_width_q)}));
	endproperty
	a_motion_clamp: assert property (p_motion_clamp) else $error("x left the screen");
`endif

endmodule

`default_nettype wire
